// File: rtl/region_mosaic_pixelate_defines.svh
// Assertion helpers used by the checker file rmp_chk.sv.
`ifndef REGION_MOSAIC_PIXELATE_DEFINES_SVH
`define REGION_MOSAIC_PIXELATE_DEFINES_SVH

// Same-cycle implication, reset-qualified.
`define RMP_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, reset-qualified.
`define RMP_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: rtl/rmp_pkg.sv
`default_nettype none
package rmp_pkg;

  // Default sizing
  localparam int MaxBlockDef = 50;
  localparam int MaxWidthDef = 1024;
  localparam int MaxTilesDef = 1024;

  // Field widths
  localparam int SumW   = 20;
  localparam int DivNW  = 20;
  localparam int DivDW  = 13;
  localparam int PaddrW = 5;

  // Register indexes (paddr[4:2])
  localparam logic [2:0] RegBlockSize = 3'd0;
  localparam logic [2:0] RegFrameWidth = 3'd1;
  localparam logic [2:0] RegLeft = 3'd2;
  localparam logic [2:0] RegTop = 3'd3;
  localparam logic [2:0] RegRight = 3'd4;
  localparam logic [2:0] RegBottom = 3'd5;
  localparam logic [2:0] RegEnable = 3'd6;

  // Effective configuration seen by the datapath
  typedef struct packed {
    logic [5:0]  blk;
    logic [10:0] fw;
    logic [9:0]  left;
    logic [9:0]  top;
    logic [9:0]  right;
    logic [9:0]  bottom;
    logic        en;
  } cfg_t;

endpackage
`default_nettype wire

// File: rtl/rmp_in_if.sv
`default_nettype none
interface rmp_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic [9:0]  pix_col;
  logic [10:0] pix_row;
  logic [7:0]  chan_first;
  logic [7:0]  chan_second;
  logic [7:0]  chan_third;

  modport source (output valid, req_type, pix_col, pix_row, chan_first, chan_second,
                  chan_third, input ready);
  modport sink (input valid, req_type, pix_col, pix_row, chan_first, chan_second,
                chan_third, output ready);
endinterface
`default_nettype wire

// File: rtl/rmp_out_if.sv
`default_nettype none
interface rmp_out_if;
  logic       valid;
  logic       ready;
  logic [9:0] out_col;
  logic [9:0] out_row;
  logic [7:0] out_first;
  logic [7:0] out_second;
  logic [7:0] out_third;

  modport source (output valid, out_col, out_row, out_first, out_second, out_third,
                  input ready);
  modport sink (input valid, out_col, out_row, out_first, out_second, out_third,
                output ready);
endinterface
`default_nettype wire

// File: rtl/rmp_div.sv
`default_nettype none
module rmp_div
  import rmp_pkg::*;
#(
  parameter int NW = DivNW,
  parameter int DW = DivDW
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [DW-1:0] divisor_i,
  output logic               done_o,
  output logic [NW-1:0]      quot_o,
  output logic [DW-1:0]      rem_o
);

  localparam int CntW = $clog2(NW + 1);

  logic            busy_q, busy_d;
  logic            done_q, done_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [NW-1:0]   quo_q, quo_d;
  logic [DW-1:0]   rem_q, rem_d;
  logic [DW-1:0]   dvs_q, dvs_d;
  logic [DW:0]     trial;

  // One restoring step per cycle
  always_comb begin
    trial  = {rem_q, quo_q[NW-1]};
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = CntW'(NW);
      quo_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = DW'(trial - {1'b0, dvs_q});
        quo_d = {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_d = trial[DW-1:0];
        quo_d = {quo_q[NW-2:0], 1'b0};
      end
      cnt_d = cnt_q - CntW'(1);
      if (cnt_q == CntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  assign quot_o = quo_q;
  assign rem_o  = rem_q;

endmodule
`default_nettype wire

// File: rtl/rmp_core.sv
`default_nettype none
module rmp_core
  import rmp_pkg::*;
#(
  parameter int MAX_BLOCK = MaxBlockDef,
  parameter int MAX_WIDTH = MaxWidthDef,
  parameter int MAX_TILES = MaxTilesDef
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  wire cfg_t   cfg_i,
  rmp_in_if.sink      pix_in,
  rmp_out_if.source   pix_out
);

  localparam int PixAw  = $clog2(MAX_BLOCK * MAX_WIDTH);
  localparam int TileAw = $clog2(2 * MAX_TILES);

  typedef enum logic [11:0] {
    S_IDLE = 12'b0000_0000_0001,
    S_DROW = 12'b0000_0000_0010,
    S_DCOL = 12'b0000_0000_0100,
    S_DBO  = 12'b0000_0000_1000,
    S_DBS  = 12'b0000_0001_0000,
    S_RD   = 12'b0000_0010_0000,
    S_CALC = 12'b0000_0100_0000,
    S_CNT  = 12'b0000_1000_0000,
    S_AVS  = 12'b0001_0000_0000,
    S_AV0  = 12'b0010_0000_0000,
    S_AV1  = 12'b0100_0000_0000,
    S_OUT  = 12'b1000_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Request and per-item working registers
  logic        req_q;
  logic [9:0]  col_q;
  logic [10:0] row_q;
  logic [23:0] ch_q;
  logic [5:0]  rmod_q, cph_q, rph_q;
  logic [9:0]  tc_q, bo_q, bs_q;
  logic        in_o_q, in_s_q;
  logic [16:0] x1_q, y1_q;
  logic [6:0]  w_q, h_q;
  logic [DivDW-1:0] cnt_q;
  logic [59:0] te_q;
  logic [7:0]  a0_q, a1_q;
  logic        av_done_q;

  // Output register
  logic        ov_q, ov_d;
  logic [9:0]  ocol_q, orow_q;
  logic [7:0]  o0_q, o1_q, o2_q;

  // Memories
  logic [23:0] pix_mem [MAX_BLOCK * MAX_WIDTH];
  logic [59:0] tile_mem [2 * MAX_TILES];
  logic [23:0] pix_rd_q;
  logic [59:0] tile_rd_q;
  logic [PixAw-1:0]  pix_addr;
  logic [TileAw-1:0] tile_addr;
  logic        tile_bank;

  // Divider hookup
  logic             div_start, div_done;
  logic [DivNW-1:0] div_dvd, div_q;
  logic [DivDW-1:0] div_dvs, div_r;

  logic        accept;
  logic [10:0] orow;
  logic        emit;
  logic        col_in, row_o_in, row_s_in;
  logic [10:0] xe;
  logic [16:0] wr, hr;
  logic [7:0]  avg_sat;
  logic [SumW-1:0] s0, s1, s2;
  logic [59:0] base;

  assign accept = pix_in.valid && pix_in.ready;
  assign pix_in.ready = (state_q == S_IDLE);

  // Geometry of the emitted and stored positions
  assign orow     = row_q - 11'(cfg_i.blk);
  assign emit     = (row_q >= 11'(cfg_i.blk)) && !orow[10];
  assign col_in   = cfg_i.en && (col_q >= cfg_i.left) && (col_q <= cfg_i.right)
                    && ({1'b0, col_q} < cfg_i.fw);
  assign row_o_in = (orow >= {1'b0, cfg_i.top}) && (orow <= {1'b0, cfg_i.bottom});
  assign row_s_in = (row_q >= {1'b0, cfg_i.top}) && (row_q <= {1'b0, cfg_i.bottom});
  assign xe       = (cfg_i.right < 10'(cfg_i.fw - 11'd1)) ? {1'b0, cfg_i.right}
                                                          : (cfg_i.fw - 11'd1);
  assign wr       = 17'(xe) - x1_q + 17'd1;
  assign hr       = 17'({1'b0, cfg_i.bottom}) - y1_q + 17'd1;
  assign avg_sat  = (div_q > DivNW'(255)) ? 8'd255 : div_q[7:0];

  // Tile sums updated with the stored pixel
  assign base = (rph_q == 6'd0 && cph_q == 6'd0) ? 60'd0 : tile_rd_q;
  assign s0   = base[19:0] + SumW'(ch_q[7:0]);
  assign s1   = base[39:20] + SumW'(ch_q[15:8]);
  assign s2   = base[59:40] + SumW'(ch_q[23:16]);

  // Divider operand selection
  always_comb begin
    div_start = 1'b0;
    div_dvd   = '0;
    div_dvs   = DivDW'(cfg_i.blk);
    case (state_q)
      S_IDLE: begin
        div_start = accept;
        div_dvd   = DivNW'(pix_in.pix_row);
      end
      S_DROW: begin
        div_start = div_done && ({1'b0, col_q} < cfg_i.fw);
        div_dvd   = (col_q >= cfg_i.left) ? DivNW'(col_q - cfg_i.left) : '0;
      end
      S_DCOL: begin
        div_start = div_done;
        div_dvd   = (orow >= {1'b0, cfg_i.top}) ? DivNW'(orow - {1'b0, cfg_i.top}) : '0;
      end
      S_DBO: begin
        div_start = div_done;
        div_dvd   = (row_q >= {1'b0, cfg_i.top}) ? DivNW'(row_q - {1'b0, cfg_i.top}) : '0;
      end
      S_AVS: begin
        div_start = 1'b1;
        div_dvd   = te_q[19:0];
        div_dvs   = cnt_q;
      end
      S_AV0: begin
        div_start = div_done;
        div_dvd   = te_q[39:20];
        div_dvs   = cnt_q;
      end
      S_AV1: begin
        div_start = div_done;
        div_dvd   = te_q[59:40];
        div_dvs   = cnt_q;
      end
      default: ;
    endcase
  end

  rmp_div #(.NW(DivNW), .DW(DivDW)) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (div_dvs),
    .done_o     (div_done),
    .quot_o     (div_q),
    .rem_o      (div_r)
  );

  // Sequencer
  always_comb begin
    state_d = state_q;
    ov_d    = ov_q && !pix_out.ready;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_DROW;
      S_DROW: if (div_done) state_d = ({1'b0, col_q} < cfg_i.fw) ? S_DCOL : S_IDLE;
      S_DCOL: if (div_done) state_d = S_DBO;
      S_DBO:  if (div_done) state_d = S_DBS;
      S_DBS:  if (div_done) state_d = S_RD;
      S_RD:   state_d = S_CALC;
      S_CALC: state_d = S_CNT;
      S_CNT: begin
        if (!emit) state_d = S_IDLE;
        else if (in_o_q) state_d = S_AVS;
        else state_d = S_OUT;
      end
      S_AVS:  state_d = S_AV0;
      S_AV0:  if (div_done) state_d = S_AV1;
      S_AV1:  if (div_done) state_d = S_OUT;
      S_OUT: begin
        if (div_done || av_done_q || !in_o_q) begin
          if (!ov_q || pix_out.ready) begin
            ov_d    = 1'b1;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      ov_q    <= ov_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q <= pix_in.req_type;
      col_q <= pix_in.pix_col;
      row_q <= pix_in.pix_row;
      ch_q  <= {pix_in.chan_third, pix_in.chan_second, pix_in.chan_first};
    end
    if (state_q == S_DROW && div_done) begin
      rmod_q <= div_r[5:0];
      in_o_q <= col_in && row_o_in;
      in_s_q <= col_in && row_s_in && !req_q;
    end
    if (state_q == S_DCOL && div_done) begin
      tc_q  <= div_q[9:0];
      cph_q <= div_r[5:0];
      if (32'(div_q) >= MAX_TILES) begin
        in_o_q <= 1'b0;
        in_s_q <= 1'b0;
      end
    end
    if (state_q == S_DBO && div_done) begin
      bo_q <= div_q[9:0];
      x1_q <= 17'(cfg_i.left) + 17'(tc_q) * 17'(cfg_i.blk);
    end
    if (state_q == S_DBS && div_done) begin
      bs_q  <= div_q[9:0];
      rph_q <= div_r[5:0];
      y1_q  <= 17'(cfg_i.top) + 17'(bo_q) * 17'(cfg_i.blk);
    end
    if (state_q == S_CALC) begin
      te_q <= tile_rd_q;
      w_q  <= (wr > 17'(cfg_i.blk)) ? 7'(cfg_i.blk) : wr[6:0];
      h_q  <= (hr > 17'(cfg_i.blk)) ? 7'(cfg_i.blk) : hr[6:0];
    end
    if (state_q == S_CNT) cnt_q <= DivDW'(w_q * h_q);
    if (state_q == S_AV0 && div_done) a0_q <= avg_sat;
    if (state_q == S_AV1 && div_done) a1_q <= avg_sat;
    // Hold completion of the last average while the output is stalled
    if (state_q == S_OUT) av_done_q <= av_done_q || div_done;
    else av_done_q <= 1'b0;
  end

  // Output register load
  always_ff @(posedge clk_i) begin
    if (state_q == S_OUT && state_d == S_IDLE) begin
      ocol_q <= col_q;
      orow_q <= orow[9:0];
      if (in_o_q) begin
        o0_q <= a0_q;
        o1_q <= a1_q;
        o2_q <= avg_sat;
      end else begin
        o0_q <= pix_rd_q[7:0];
        o1_q <= pix_rd_q[15:8];
        o2_q <= pix_rd_q[23:16];
      end
    end
  end

  // Row delay store: read in RD, write in CALC
  assign pix_addr = PixAw'(32'(rmod_q) * MAX_WIDTH + 32'(col_q));

  always_ff @(posedge clk_i) begin
    if (state_q == S_CALC && !req_q) pix_mem[pix_addr] <= ch_q;
    if (state_q == S_RD) pix_rd_q <= pix_mem[pix_addr];
  end

  // Tile sums: emit read in RD, store read in CALC, write back in CNT
  assign tile_bank = (state_q == S_RD) ? bo_q[0] : bs_q[0];
  assign tile_addr = TileAw'(32'(tile_bank) * MAX_TILES + 32'(tc_q));

  always_ff @(posedge clk_i) begin
    if (state_q == S_CNT && in_s_q) tile_mem[tile_addr] <= {s2, s1, s0};
    if (state_q == S_RD || state_q == S_CALC) tile_rd_q <= tile_mem[tile_addr];
  end

  assign pix_out.valid      = ov_q;
  assign pix_out.out_col    = ocol_q;
  assign pix_out.out_row    = orow_q;
  assign pix_out.out_first  = o0_q;
  assign pix_out.out_second = o1_q;
  assign pix_out.out_third  = o2_q;

endmodule
`default_nettype wire

// File: rtl/region_mosaic_pixelate.sv
// Channel     Dir   Handshake      Payload
// pix_in      in    valid/ready    req_type, pix_col, pix_row, chan_first..third
// pix_out     out   valid/ready    out_col, out_row, out_first..third
// apb         in    psel/penable   paddr, pwdata, prdata (7 registers at 4*i)
//
// One request at a time; its duration is set by the shared 20-step divider: four
// coordinate divisions for a pass-through pixel, plus three tile averages for a
// mosaic pixel. A column outside the frame returns to idle after the first division.
// Reset is asynchronous, active low; memories are not cleared.
// The result waits in an output register; a stalled output holds the sequencer
// only at its last step.
`default_nettype none
module region_mosaic_pixelate
  import rmp_pkg::*;
#(
  parameter int MAX_BLOCK = MaxBlockDef,
  parameter int MAX_WIDTH = MaxWidthDef,
  parameter int MAX_TILES = MaxTilesDef
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [PaddrW-1:0] paddr,
  input  wire logic [31:0]       pwdata,
  output logic [31:0]            prdata,
  output logic                   pready,
  rmp_in_if.sink                 pix_in,
  rmp_out_if.source              pix_out
);

  logic [5:0]  blk_q;
  logic [10:0] fw_q;
  logic [9:0]  left_q, top_q, right_q, bottom_q;
  logic        en_q;
  logic        wr_en;
  cfg_t        cfg;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  // Register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      blk_q    <= 6'd5;
      fw_q     <= 11'd640;
      left_q   <= '0;
      top_q    <= '0;
      right_q  <= '0;
      bottom_q <= '0;
      en_q     <= 1'b0;
    end else if (wr_en) begin
      unique case (paddr[4:2])
        RegBlockSize:  blk_q    <= pwdata[5:0];
        RegFrameWidth: fw_q     <= pwdata[10:0];
        RegLeft:       left_q   <= pwdata[9:0];
        RegTop:        top_q    <= pwdata[9:0];
        RegRight:      right_q  <= pwdata[9:0];
        RegBottom:     bottom_q <= pwdata[9:0];
        RegEnable:     en_q     <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    unique case (paddr[4:2])
      RegBlockSize:  prdata = 32'(blk_q);
      RegFrameWidth: prdata = 32'(fw_q);
      RegLeft:       prdata = 32'(left_q);
      RegTop:        prdata = 32'(top_q);
      RegRight:      prdata = 32'(right_q);
      RegBottom:     prdata = 32'(bottom_q);
      RegEnable:     prdata = 32'(en_q);
      default:       prdata = '0;
    endcase
  end

  // Clamp block size and width to their working ranges
  always_comb begin
    cfg.blk    = (blk_q == 6'd0) ? 6'd1
               : ((32'(blk_q) > MAX_BLOCK) ? 6'(MAX_BLOCK) : blk_q);
    cfg.fw     = (fw_q == 11'd0) ? 11'd1
               : ((32'(fw_q) > MAX_WIDTH) ? 11'(MAX_WIDTH) : fw_q);
    cfg.left   = left_q;
    cfg.top    = top_q;
    cfg.right  = right_q;
    cfg.bottom = bottom_q;
    cfg.en     = en_q;
  end

  rmp_core #(
    .MAX_BLOCK (MAX_BLOCK),
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_TILES (MAX_TILES)
  ) u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .pix_in  (pix_in),
    .pix_out (pix_out)
  );

endmodule
`default_nettype wire

// File: rtl/rmp_chk.sv
`default_nettype none
`include "region_mosaic_pixelate_defines.svh"
module rmp_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid,
  input wire logic in_ready,
  input wire logic out_valid,
  input wire logic out_ready
);

  // A request occupies the block: no back-to-back accept
  `RMP_ASSERT_NXT(a_busy_after_accept, clk_i, rst_ni, in_valid && in_ready, !in_ready)

  // A result appears only while the input side is held off
  `RMP_ASSERT_IMP(a_out_from_busy, clk_i, rst_ni, $rose(out_valid), $past(!in_ready))

  // A pending result is not dropped
  `RMP_ASSERT_NXT(a_out_hold, clk_i, rst_ni, out_valid && !out_ready, out_valid)

endmodule

bind region_mosaic_pixelate rmp_chk u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .in_valid  (pix_in.valid),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready)
);
`default_nettype wire
